/* rtl/tls13_client_hello_parser_top_assert.svh */
// assertion macros for the clienthello parser top level
// expects i_clk and i_rst_n in the scope where the macros are used
`ifndef TLS13_CLIENT_HELLO_PARSER_TOP_ASSERT_SVH
`define TLS13_CLIENT_HELLO_PARSER_TOP_ASSERT_SVH

// condition must hold in the same cycle as the trigger
`define TCHP_ASSERT_SAME(lbl, trig, cond) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (trig) |-> (cond)) else $error("tchp check failed");

// condition must hold in the cycle after the trigger
`define TCHP_ASSERT_NEXT(lbl, trig, cond) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (trig) |=> (cond)) else $error("tchp check failed");

`endif

/* rtl/tchp_pkg.sv */
`timescale 1ns / 1ps
// shared types and constants of the clienthello parser
// no dependencies
package tchp_pkg;

    typedef enum logic [4:0] {
        P_TYPE, P_LEN, P_VER, P_RANDOM, P_SIDLEN, P_SID, P_CSLEN, P_CSENT,
        P_COMP, P_EXTLEN, P_EXTHDR, P_SKIP, P_KSVEC, P_KSGRP, P_KSKLEN, P_KSKEY,
        P_SALEN, P_SABODY, P_SGLEN, P_SGENT, P_SVLEN, P_SVENT, P_PMLEN, P_PMENT,
        P_PSKIDS, P_PSKIDLEN, P_PSKID, P_PSKPAD, P_PSKBHDR, P_PSKBIND, P_FAIL
    } t_phase;

    typedef enum logic [1:0] {
        ST_BYTE, ST_CPL, ST_OUT
    } t_eng_state;

    localparam logic [1:0] STATUS_OK       = 2'd0;
    localparam logic [1:0] STATUS_BAD_TYPE = 2'd1;
    localparam logic [1:0] STATUS_DECODE   = 2'd2;
    localparam logic [1:0] STATUS_ILLEGAL  = 2'd3;

    localparam logic [1:0] CFG_CIPHER = 2'd0;
    localparam logic [1:0] CFG_GROUP  = 2'd1;
    localparam logic [1:0] CFG_PKLEN  = 2'd2;

    localparam logic [15:0] CFG_CIPHER_RST = 16'd4865;
    localparam logic [15:0] CFG_GROUP_RST  = 16'd29;
    localparam logic [15:0] CFG_PKLEN_RST  = 16'd32;

    localparam logic [15:0] EXT_PSK       = 16'd41;
    localparam logic [15:0] EXT_VERSIONS  = 16'd43;
    localparam logic [15:0] EXT_PSK_MODES = 16'd45;
    localparam logic [15:0] EXT_KEY_SHARE = 16'd51;
    localparam logic [15:0] EXT_GROUPS    = 16'd10;
    localparam logic [15:0] EXT_SIG_ALGS  = 16'd13;

    localparam logic [31:0] HS_CLIENT_HELLO = 32'd1;
    localparam logic [15:0] LEGACY_VERSION  = 16'h0303;
    localparam logic [15:0] TLS13_VERSION   = 16'h0304;
    localparam logic [15:0] NULL_COMP       = 16'h0100;
    localparam logic [7:0]  MAX_SID_LEN     = 8'd32;
    localparam logic [31:0] PSK_DHE_KE      = 32'd1;
    localparam logic [7:0]  BINDER_LEN      = 8'd32;

    localparam int FLG_CIPHER   = 0;
    localparam int FLG_KEYSHARE = 1;
    localparam int FLG_TLS13    = 2;
    localparam int FLG_GROUPS   = 3;
    localparam int FLG_GROUP_OK = 4;
    localparam int FLG_PSKDHE   = 5;
    localparam int FLG_PSK      = 6;
    localparam int FLG_KSMATCH  = 7;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } t_beat;

    typedef struct packed {
        logic [15:0] cipher;
        logic [15:0] group;
        logic [15:0] pk_len;
    } t_cfg;

    typedef struct packed {
        logic [1:0]  status;
        logic [5:0]  sid_len;
        logic [13:0] ks_off;
        logic [13:0] sa_off;
        logic [13:0] sa_len;
        logic        psk;
        logic [13:0] id_off;
        logic [13:0] id_len;
        logic [13:0] trunc;
        logic [13:0] bind_off;
    } t_result;

    typedef struct packed {
        logic pop;
        logic res_load;
    } t_eng_stat;

endpackage

/* rtl/tchp_in_if.sv */
`timescale 1ns / 1ps
// byte channel into the clienthello parser
// no dependencies
interface tchp_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       last_byte;

    modport source (output valid, output data_byte, output last_byte, input ready);
    modport sink (input valid, input data_byte, input last_byte, output ready);
endinterface

/* rtl/tchp_out_if.sv */
`timescale 1ns / 1ps
// result channel out of the clienthello parser
// no dependencies
interface tchp_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  status;
    logic [5:0]  session_id_len;
    logic [13:0] key_share_offset;
    logic [13:0] sig_algs_offset;
    logic [13:0] sig_algs_len;
    logic        psk_offered;
    logic [13:0] psk_identity_offset;
    logic [13:0] psk_identity_len;
    logic [13:0] binder_trunc_len;
    logic [13:0] binder_offset;

    modport source (output valid, input ready, output status, output session_id_len,
        output key_share_offset, output sig_algs_offset, output sig_algs_len,
        output psk_offered, output psk_identity_offset, output psk_identity_len,
        output binder_trunc_len, output binder_offset);
    modport sink (input valid, output ready, input status, input session_id_len,
        input key_share_offset, input sig_algs_offset, input sig_algs_len,
        input psk_offered, input psk_identity_offset, input psk_identity_len,
        input binder_trunc_len, input binder_offset);
endinterface

/* rtl/tchp_front.sv */
`timescale 1ns / 1ps
// front end: takes byte beats and holds them in a two-entry queue
// depends on tchp_pkg and tchp_in_if
module tchp_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    tchp_in_if.sink           s_in,
    input  logic              i_pop,
    output logic              o_q_valid,
    output tchp_pkg::t_beat   o_q_beat
);

    tchp_pkg::t_beat r_buf [2];
    logic            r_wp, r_rp;
    logic [1:0]      r_cnt;
    logic            push;

    assign s_in.ready = (r_cnt != 2'd2);
    assign push       = s_in.valid && s_in.ready;
    assign o_q_valid  = (r_cnt != 2'd0);
    assign o_q_beat   = r_buf[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push) r_wp <= ~r_wp;
            if (i_pop) r_rp <= ~r_rp;
            r_cnt <= r_cnt + 2'(push) - 2'(i_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_buf[r_wp].data <= s_in.data_byte;
            r_buf[r_wp].last <= s_in.last_byte;
        end
    end

endmodule

/* rtl/tchp_parser.sv */
`timescale 1ns / 1ps
// back end: message walker, extension checks and result register
// depends on tchp_pkg and tchp_out_if
module tchp_parser #(
    parameter int MAX_MSG_BYTES  = 16384,
    parameter int MAX_EXTENSIONS = 24
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  tchp_pkg::t_cfg       i_cfg,
    input  logic                 i_q_valid,
    input  tchp_pkg::t_beat      i_q_beat,
    output tchp_pkg::t_eng_stat  o_stat,
    tchp_out_if.source           m_out
);

    localparam int PW = $clog2(MAX_MSG_BYTES + 2);
    localparam int EW = ((PW > 16) ? PW : 16) + 1;
    localparam int IW = (MAX_EXTENSIONS > 1) ? $clog2(MAX_EXTENSIONS) : 1;
    localparam int CW = $clog2(MAX_EXTENSIONS + 1);

    tchp_pkg::t_eng_state r_eng, n_eng;
    tchp_pkg::t_phase     r_phase, n_phase;
    logic [PW-1:0] r_pos, n_pos, r_nxt, n_nxt;
    logic [15:0]   r_fr, n_fr;
    logic [31:0]   r_word, n_word;
    logic [EW-1:0] r_exts_end, n_exts_end, r_ext_end, n_ext_end;
    logic [EW-1:0] r_inner_end, n_inner_end;
    logic [15:0]   r_seen [MAX_EXTENSIONS];
    logic [CW-1:0] r_cnt, n_cnt;
    logic [7:0]    r_flags, n_flags;
    logic [1:0]    r_err, n_err;
    logic          r_last, n_last;
    logic [5:0]    r_sid_len, n_sid_len;
    logic [13:0]   r_ks_off, n_ks_off, r_sa_off, n_sa_off, r_sa_len, n_sa_len;
    logic [15:0]   r_ks_len, n_ks_len;
    logic [13:0]   r_id_off, n_id_off, r_id_len, n_id_len;
    logic [13:0]   r_trunc, n_trunc, r_bind_off, n_bind_off;
    logic [7:0]    r_bind_len, n_bind_len;

    logic          r_ov;
    tchp_pkg::t_result r_res, n_res;

    logic          pop, res_load;
    logic          seen_we;
    logic [IW-1:0] seen_idx;
    logic          dup;
    logic [EW-1:0] nx, hdr_end;
    logic [31:0]   nx32;
    logic [24:0]   len_sum;
    logic          c_fail, c_beg, c_done, c_list;
    tchp_pkg::t_phase c_ph, c_lph;
    logic [15:0]   c_n, c_lsz;
    logic [EW-1:0] c_lend;
    logic [1:0]    st;

    assign nx      = EW'(r_nxt);
    assign nx32    = 32'(r_nxt);
    assign hdr_end = nx + EW'(r_word[15:0]);
    assign len_sum = 25'd4 + 25'(r_word[23:0]);

    // parallel compare of the extension type against every type seen so far
    always_comb begin
        dup = 1'b0;
        for (int k = 0; k < MAX_EXTENSIONS; k++) begin
            if (CW'(k) < r_cnt && r_seen[k] == r_word[31:16]) dup = 1'b1;
        end
    end

    // engine next state
    always_comb begin
        n_eng = r_eng;
        case (r_eng)
            tchp_pkg::ST_BYTE: begin
                if (i_q_valid) begin
                    if (n_phase != tchp_pkg::P_FAIL && n_fr == 16'd0)
                        n_eng = tchp_pkg::ST_CPL;
                    else if (i_q_beat.last)
                        n_eng = tchp_pkg::ST_OUT;
                end
            end
            tchp_pkg::ST_CPL: begin
                if (!(n_phase != tchp_pkg::P_FAIL && n_fr == 16'd0))
                    n_eng = r_last ? tchp_pkg::ST_OUT : tchp_pkg::ST_BYTE;
            end
            tchp_pkg::ST_OUT: begin
                if (res_load) n_eng = tchp_pkg::ST_BYTE;
            end
            default: n_eng = tchp_pkg::ST_BYTE;
        endcase
    end

    // final status from the state left by the last byte
    always_comb begin
        if (r_err != tchp_pkg::STATUS_OK)
            st = r_err;
        else if (!(r_phase == tchp_pkg::P_EXTHDR && r_fr == 16'd4 && nx == r_exts_end))
            st = tchp_pkg::STATUS_DECODE;
        else if (!r_flags[tchp_pkg::FLG_CIPHER] || !r_flags[tchp_pkg::FLG_KEYSHARE] ||
                 r_ks_len != i_cfg.pk_len || !r_flags[tchp_pkg::FLG_TLS13] ||
                 !r_flags[tchp_pkg::FLG_GROUPS] || !r_flags[tchp_pkg::FLG_GROUP_OK] ||
                 (r_flags[tchp_pkg::FLG_PSK] &&
                  (r_bind_len != tchp_pkg::BINDER_LEN || !r_flags[tchp_pkg::FLG_PSKDHE])))
            st = tchp_pkg::STATUS_ILLEGAL;
        else
            st = tchp_pkg::STATUS_OK;
        n_res = '0;
        n_res.status = st;
        if (st == tchp_pkg::STATUS_OK) begin
            n_res.sid_len = r_sid_len;
            n_res.ks_off  = r_ks_off;
            n_res.sa_off  = r_sa_off;
            n_res.sa_len  = r_sa_len;
            if (r_flags[tchp_pkg::FLG_PSK]) begin
                n_res.psk      = 1'b1;
                n_res.id_off   = r_id_off;
                n_res.id_len   = r_id_len;
                n_res.trunc    = r_trunc;
                n_res.bind_off = r_bind_off;
            end
        end
    end

    // datapath outputs of the engine
    always_comb begin
        n_phase = r_phase;  n_pos = r_pos;  n_nxt = r_nxt;  n_fr = r_fr;
        n_word = r_word;  n_exts_end = r_exts_end;  n_ext_end = r_ext_end;
        n_inner_end = r_inner_end;  n_cnt = r_cnt;  n_flags = r_flags;
        n_err = r_err;  n_last = r_last;  n_sid_len = r_sid_len;
        n_ks_off = r_ks_off;  n_ks_len = r_ks_len;  n_sa_off = r_sa_off;
        n_sa_len = r_sa_len;  n_id_off = r_id_off;  n_id_len = r_id_len;
        n_trunc = r_trunc;  n_bind_off = r_bind_off;  n_bind_len = r_bind_len;
        pop = 1'b0;  res_load = 1'b0;  seen_we = 1'b0;  seen_idx = r_cnt[IW-1:0];
        c_fail = 1'b0;  c_beg = 1'b0;  c_done = 1'b0;  c_list = 1'b0;
        c_ph = tchp_pkg::P_TYPE;  c_lph = tchp_pkg::P_TYPE;
        c_n = 16'd0;  c_lsz = 16'd0;  c_lend = r_inner_end;

        case (r_eng)
            tchp_pkg::ST_BYTE: begin
                if (i_q_valid) begin
                    pop    = 1'b1;
                    n_last = i_q_beat.last;
                    n_nxt  = r_pos + PW'(1);
                    if (r_phase != tchp_pkg::P_FAIL) begin
                        if (r_phase > tchp_pkg::P_LEN && EW'(r_pos) >= r_exts_end)
                            c_fail = 1'b1;
                        else if (r_phase >= tchp_pkg::P_SKIP && EW'(r_pos) >= r_ext_end)
                            c_fail = 1'b1;
                        else begin
                            n_word = {r_word[23:0], i_q_beat.data};
                            if (r_fr != 16'd0) n_fr = r_fr - 16'd1;
                        end
                    end
                    if (r_pos < PW'(MAX_MSG_BYTES)) n_pos = r_pos + PW'(1);
                end
            end
            tchp_pkg::ST_CPL: begin
                case (r_phase)
                    tchp_pkg::P_TYPE: begin
                        if (r_word != tchp_pkg::HS_CLIENT_HELLO) begin
                            n_err   = tchp_pkg::STATUS_BAD_TYPE;
                            n_phase = tchp_pkg::P_FAIL;
                        end else begin
                            c_beg = 1'b1;  c_ph = tchp_pkg::P_LEN;  c_n = 16'd3;
                        end
                    end
                    tchp_pkg::P_LEN: begin
                        if (len_sum > 25'(MAX_MSG_BYTES)) c_fail = 1'b1;
                        else begin
                            n_exts_end = EW'(len_sum);
                            c_beg = 1'b1;  c_ph = tchp_pkg::P_VER;  c_n = 16'd2;
                        end
                    end
                    tchp_pkg::P_VER: begin
                        if (r_word != 32'(tchp_pkg::LEGACY_VERSION)) c_fail = 1'b1;
                        else begin
                            c_beg = 1'b1;  c_ph = tchp_pkg::P_RANDOM;  c_n = 16'd32;
                        end
                    end
                    tchp_pkg::P_RANDOM: begin
                        c_beg = 1'b1;  c_ph = tchp_pkg::P_SIDLEN;  c_n = 16'd1;
                    end
                    tchp_pkg::P_SIDLEN: begin
                        if (r_word > 32'(tchp_pkg::MAX_SID_LEN)) c_fail = 1'b1;
                        else begin
                            n_sid_len = r_word[5:0];
                            c_beg = 1'b1;  c_ph = tchp_pkg::P_SID;  c_n = 16'(r_word[7:0]);
                        end
                    end
                    tchp_pkg::P_SID: begin
                        c_beg = 1'b1;  c_ph = tchp_pkg::P_CSLEN;  c_n = 16'd2;
                    end
                    tchp_pkg::P_CSLEN: begin
                        if (r_word[0]) c_fail = 1'b1;
                        else if (r_word[15:0] == 16'd0) begin
                            c_beg = 1'b1;  c_ph = tchp_pkg::P_COMP;  c_n = 16'd2;
                        end else begin
                            n_inner_end = hdr_end;
                            c_beg = 1'b1;  c_ph = tchp_pkg::P_CSENT;  c_n = 16'd2;
                        end
                    end
                    tchp_pkg::P_CSENT: begin
                        if (r_word == 32'(i_cfg.cipher)) n_flags[tchp_pkg::FLG_CIPHER] = 1'b1;
                        c_beg = 1'b1;  c_n = 16'd2;
                        c_ph = (nx < r_inner_end) ? tchp_pkg::P_CSENT : tchp_pkg::P_COMP;
                    end
                    tchp_pkg::P_COMP: begin
                        if (r_word != 32'(tchp_pkg::NULL_COMP)) c_fail = 1'b1;
                        else begin
                            c_beg = 1'b1;  c_ph = tchp_pkg::P_EXTLEN;  c_n = 16'd2;
                        end
                    end
                    tchp_pkg::P_EXTLEN: begin
                        if (hdr_end != r_exts_end) c_fail = 1'b1;
                        else begin
                            c_beg = 1'b1;  c_ph = tchp_pkg::P_EXTHDR;  c_n = 16'd4;
                        end
                    end
                    tchp_pkg::P_EXTHDR: begin
                        n_ext_end = hdr_end;
                        if (hdr_end > r_exts_end || r_flags[tchp_pkg::FLG_PSK] || dup ||
                            r_cnt >= CW'(MAX_EXTENSIONS))
                            c_fail = 1'b1;
                        else begin
                            seen_we = 1'b1;
                            n_cnt   = r_cnt + CW'(1);
                            c_beg   = 1'b1;
                            c_n     = 16'd2;
                            case (r_word[31:16])
                                tchp_pkg::EXT_KEY_SHARE: c_ph = tchp_pkg::P_KSVEC;
                                tchp_pkg::EXT_SIG_ALGS:  c_ph = tchp_pkg::P_SALEN;
                                tchp_pkg::EXT_GROUPS:    c_ph = tchp_pkg::P_SGLEN;
                                tchp_pkg::EXT_VERSIONS: begin
                                    c_ph = tchp_pkg::P_SVLEN;  c_n = 16'd1;
                                end
                                tchp_pkg::EXT_PSK_MODES: begin
                                    c_ph = tchp_pkg::P_PMLEN;  c_n = 16'd1;
                                end
                                tchp_pkg::EXT_PSK: begin
                                    n_flags[tchp_pkg::FLG_PSK] = 1'b1;
                                    c_ph = tchp_pkg::P_PSKIDS;
                                end
                                default: begin
                                    c_ph = tchp_pkg::P_SKIP;  c_n = r_word[15:0];
                                end
                            endcase
                        end
                    end
                    tchp_pkg::P_SKIP, tchp_pkg::P_SABODY: c_done = 1'b1;
                    tchp_pkg::P_KSVEC: begin
                        n_inner_end = hdr_end;
                        if (hdr_end > r_ext_end) c_fail = 1'b1;
                        else begin
                            c_list = 1'b1;  c_lph = tchp_pkg::P_KSGRP;
                            c_lsz = 16'd2;  c_lend = hdr_end;
                        end
                    end
                    tchp_pkg::P_KSGRP: begin
                        n_flags[tchp_pkg::FLG_KSMATCH] = (r_word == 32'(i_cfg.group));
                        c_beg = 1'b1;  c_ph = tchp_pkg::P_KSKLEN;  c_n = 16'd2;
                    end
                    tchp_pkg::P_KSKLEN: begin
                        if (r_flags[tchp_pkg::FLG_KSMATCH]) begin
                            n_ks_off = nx32[13:0];
                            n_ks_len = r_word[15:0];
                            n_flags[tchp_pkg::FLG_KEYSHARE] = 1'b1;
                        end
                        c_beg = 1'b1;  c_ph = tchp_pkg::P_KSKEY;  c_n = r_word[15:0];
                    end
                    tchp_pkg::P_KSKEY: begin
                        c_list = 1'b1;  c_lph = tchp_pkg::P_KSGRP;  c_lsz = 16'd2;
                    end
                    tchp_pkg::P_SALEN: begin
                        n_sa_off = nx32[13:0];
                        n_sa_len = r_word[13:0];
                        c_beg = 1'b1;  c_ph = tchp_pkg::P_SABODY;  c_n = r_word[15:0];
                    end
                    tchp_pkg::P_SGLEN: begin
                        n_flags[tchp_pkg::FLG_GROUPS] = 1'b1;
                        c_lend = nx + EW'({r_word[15:1], 1'b0});
                        n_inner_end = c_lend;
                        c_list = 1'b1;  c_lph = tchp_pkg::P_SGENT;  c_lsz = 16'd2;
                    end
                    tchp_pkg::P_SGENT: begin
                        if (r_word == 32'(i_cfg.group)) n_flags[tchp_pkg::FLG_GROUP_OK] = 1'b1;
                        c_list = 1'b1;  c_lph = tchp_pkg::P_SGENT;  c_lsz = 16'd2;
                    end
                    tchp_pkg::P_SVLEN: begin
                        c_lend = nx + EW'({r_word[7:1], 1'b0});
                        n_inner_end = c_lend;
                        c_list = 1'b1;  c_lph = tchp_pkg::P_SVENT;  c_lsz = 16'd2;
                    end
                    tchp_pkg::P_SVENT: begin
                        if (r_word == 32'(tchp_pkg::TLS13_VERSION))
                            n_flags[tchp_pkg::FLG_TLS13] = 1'b1;
                        c_list = 1'b1;  c_lph = tchp_pkg::P_SVENT;  c_lsz = 16'd2;
                    end
                    tchp_pkg::P_PMLEN: begin
                        c_lend = nx + EW'(r_word[7:0]);
                        n_inner_end = c_lend;
                        c_list = 1'b1;  c_lph = tchp_pkg::P_PMENT;  c_lsz = 16'd1;
                    end
                    tchp_pkg::P_PMENT: begin
                        if (r_word == tchp_pkg::PSK_DHE_KE) n_flags[tchp_pkg::FLG_PSKDHE] = 1'b1;
                        c_list = 1'b1;  c_lph = tchp_pkg::P_PMENT;  c_lsz = 16'd1;
                    end
                    tchp_pkg::P_PSKIDS: begin
                        n_inner_end = hdr_end;
                        c_beg = 1'b1;  c_ph = tchp_pkg::P_PSKIDLEN;  c_n = 16'd2;
                    end
                    tchp_pkg::P_PSKIDLEN: begin
                        n_id_off = nx32[13:0];
                        n_id_len = r_word[13:0];
                        c_beg = 1'b1;  c_ph = tchp_pkg::P_PSKID;  c_n = r_word[15:0];
                    end
                    tchp_pkg::P_PSKID: begin
                        if (r_inner_end < nx || r_inner_end > r_ext_end) c_fail = 1'b1;
                        else begin
                            c_beg = 1'b1;  c_ph = tchp_pkg::P_PSKPAD;
                            c_n = 16'(r_inner_end - nx);
                        end
                    end
                    tchp_pkg::P_PSKPAD: begin
                        n_trunc = nx32[13:0];
                        c_beg = 1'b1;  c_ph = tchp_pkg::P_PSKBHDR;  c_n = 16'd3;
                    end
                    tchp_pkg::P_PSKBHDR: begin
                        n_bind_len = r_word[7:0];
                        n_bind_off = nx32[13:0];
                        c_beg = 1'b1;  c_ph = tchp_pkg::P_PSKBIND;  c_n = 16'(r_word[7:0]);
                    end
                    tchp_pkg::P_PSKBIND: begin
                        if (nx > r_ext_end) c_fail = 1'b1;
                        else begin
                            c_beg = 1'b1;  c_ph = tchp_pkg::P_SKIP;
                            c_n = 16'(r_ext_end - nx);
                        end
                    end
                    default: c_fail = 1'b1;
                endcase
            end
            tchp_pkg::ST_OUT: begin
                if (!r_ov || m_out.ready) begin
                    res_load = 1'b1;
                    n_phase = tchp_pkg::P_TYPE;  n_pos = '0;  n_fr = 16'd1;  n_word = '0;
                    n_exts_end = '0;  n_ext_end = '0;  n_inner_end = '0;  n_cnt = '0;
                    n_flags = '0;  n_err = tchp_pkg::STATUS_OK;  n_sid_len = '0;
                    n_ks_off = '0;  n_ks_len = '0;  n_sa_off = '0;  n_sa_len = '0;
                    n_id_off = '0;  n_id_len = '0;  n_trunc = '0;  n_bind_off = '0;
                    n_bind_len = '0;
                end
            end
            default: ;
        endcase

        // list walk: next entry or close the extension
        if (c_list) begin
            if (nx < c_lend) begin
                c_beg = 1'b1;  c_ph = c_lph;  c_n = c_lsz;
            end else
                c_done = 1'b1;
        end
        if (c_done) begin
            if (nx != r_ext_end) c_fail = 1'b1;
            else begin
                c_beg = 1'b1;  c_ph = tchp_pkg::P_EXTHDR;  c_n = 16'd4;
            end
        end
        if (c_beg) begin
            n_phase = c_ph;  n_fr = c_n;  n_word = '0;
        end
        if (c_fail) begin
            n_err   = (r_err == tchp_pkg::STATUS_OK) ? tchp_pkg::STATUS_DECODE : r_err;
            n_phase = tchp_pkg::P_FAIL;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_eng <= tchp_pkg::ST_BYTE;  r_phase <= tchp_pkg::P_TYPE;
            r_pos <= '0;  r_nxt <= '0;  r_fr <= 16'd1;  r_word <= '0;
            r_exts_end <= '0;  r_ext_end <= '0;  r_inner_end <= '0;
            r_cnt <= '0;  r_flags <= '0;  r_err <= tchp_pkg::STATUS_OK;  r_last <= 1'b0;
            r_sid_len <= '0;  r_ks_off <= '0;  r_ks_len <= '0;  r_sa_off <= '0;
            r_sa_len <= '0;  r_id_off <= '0;  r_id_len <= '0;  r_trunc <= '0;
            r_bind_off <= '0;  r_bind_len <= '0;  r_ov <= 1'b0;
        end else begin
            r_eng <= n_eng;  r_phase <= n_phase;
            r_pos <= n_pos;  r_nxt <= n_nxt;  r_fr <= n_fr;  r_word <= n_word;
            r_exts_end <= n_exts_end;  r_ext_end <= n_ext_end;  r_inner_end <= n_inner_end;
            r_cnt <= n_cnt;  r_flags <= n_flags;  r_err <= n_err;  r_last <= n_last;
            r_sid_len <= n_sid_len;  r_ks_off <= n_ks_off;  r_ks_len <= n_ks_len;
            r_sa_off <= n_sa_off;  r_sa_len <= n_sa_len;  r_id_off <= n_id_off;
            r_id_len <= n_id_len;  r_trunc <= n_trunc;  r_bind_off <= n_bind_off;
            r_bind_len <= n_bind_len;
            if (res_load) r_ov <= 1'b1;
            else if (m_out.ready) r_ov <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (seen_we) r_seen[seen_idx] <= r_word[31:16];
        if (res_load) r_res <= n_res;
    end

    assign o_stat.pop      = pop;
    assign o_stat.res_load = res_load;

    assign m_out.valid               = r_ov;
    assign m_out.status              = r_res.status;
    assign m_out.session_id_len      = r_res.sid_len;
    assign m_out.key_share_offset    = r_res.ks_off;
    assign m_out.sig_algs_offset     = r_res.sa_off;
    assign m_out.sig_algs_len        = r_res.sa_len;
    assign m_out.psk_offered         = r_res.psk;
    assign m_out.psk_identity_offset = r_res.id_off;
    assign m_out.psk_identity_len    = r_res.id_len;
    assign m_out.binder_trunc_len    = r_res.trunc;
    assign m_out.binder_offset       = r_res.bind_off;

endmodule

/* rtl/tls13_client_hello_parser_top.sv */
`timescale 1ns / 1ps
// clienthello parser top level: config registers, front queue, back-end walker
// depends on tchp_pkg, tchp_in_if, tchp_out_if, tchp_front, tchp_parser
//
// i_data carries one message byte per beat with a last flag; o_res gives one
// result beat per message, after its last byte, with status and field offsets.
// config is written through i_cfg_we / i_cfg_idx / i_cfg_wdata; the user must
// write it only while idle, as the block does not enforce this. the walker
// takes each byte in its byte state, then passes through a completion step
// for every field that completes on it (zero-length fields chain). after the
// last byte it enters an output state that forms the status and loads the
// result register that drives o_res; completion steps hold off the next byte.
// a two-entry queue takes bytes while the walker is busy; a result register
// lets the walker start the next message while o_res is stalled, and the
// walker waits only when a new result is ready and the old one is not taken.
// reset returns the config registers to their defaults and the walker to the
// start of a message; the queue and result register are emptied.
module tls13_client_hello_parser_top #(
    parameter int MAX_MSG_BYTES  = 16384,
    parameter int MAX_EXTENSIONS = 24
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [15:0] i_cfg_wdata,
    tchp_in_if.sink     i_data,
    tchp_out_if.source  o_res
);

    `include "tls13_client_hello_parser_top_assert.svh"

    tchp_pkg::t_cfg      r_cfg;
    logic                q_valid;
    tchp_pkg::t_beat     q_beat;
    tchp_pkg::t_eng_stat eng_stat;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.cipher <= tchp_pkg::CFG_CIPHER_RST;
            r_cfg.group  <= tchp_pkg::CFG_GROUP_RST;
            r_cfg.pk_len <= tchp_pkg::CFG_PKLEN_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                tchp_pkg::CFG_CIPHER: r_cfg.cipher <= i_cfg_wdata;
                tchp_pkg::CFG_GROUP:  r_cfg.group  <= i_cfg_wdata;
                tchp_pkg::CFG_PKLEN:  r_cfg.pk_len <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    tchp_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .s_in      (i_data),
        .i_pop     (eng_stat.pop),
        .o_q_valid (q_valid),
        .o_q_beat  (q_beat)
    );

    tchp_parser #(
        .MAX_MSG_BYTES  (MAX_MSG_BYTES),
        .MAX_EXTENSIONS (MAX_EXTENSIONS)
    ) u_parser (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (r_cfg),
        .i_q_valid (q_valid),
        .i_q_beat  (q_beat),
        .o_stat    (eng_stat),
        .m_out     (o_res)
    );

    // walker only takes a beat the queue holds
    `TCHP_ASSERT_SAME(a_pop_has_beat, eng_stat.pop, q_valid)
    // a new result never overwrites one still waiting
    `TCHP_ASSERT_SAME(a_load_free, eng_stat.res_load, !o_res.valid || o_res.ready)
    `TCHP_ASSERT_NEXT(a_load_shows, eng_stat.res_load, o_res.valid)

endmodule
